// ===== sv/mtep_pkg.sv =====
package mtep_pkg;

    // Longest delta time or length field, in bytes.
    localparam int unsigned VLQ_MAX_BYTES = 5;

    // Input item codes (carried in the slave tuser).
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_END     = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;
    localparam logic [1:0] FUNC_NOP     = 2'd3;

    // Status byte values and upper nibbles.
    localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE   = 8'hF7;
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
    localparam logic [3:0] HI_NOTE_ON      = 4'h9;
    localparam logic [3:0] HI_CONTROL      = 4'hB;
    localparam logic [3:0] HI_PROGRAM      = 4'hC;
    localparam logic [3:0] HI_PRESSURE     = 4'hD;
    localparam logic [3:0] HI_BEND         = 4'hE;

    // Meta event types.
    localparam logic [7:0] META_TEMPO      = 8'h51;
    localparam logic [7:0] META_END        = 8'h2F;

    localparam logic [23:0] DEFAULT_TEMPO  = 24'd500000;
    localparam logic [15:0] BEND_CENTER    = 16'd8192;
    localparam logic [1:0]  TEMPO_BYTES    = 2'd3;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_SXLEN,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_NOTE_ON,
        KIND_NOTE_OFF,
        KIND_PROGRAM,
        KIND_CONTROL,
        KIND_BEND
    } kind_t;

    // One decoded result, without the tick and tempo.
    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [3:0]         channel;
        logic [6:0]         first_data;
        logic [6:0]         second_data;
        logic signed [15:0] bend;
        logic               finished;
    } evt_t;

    // Result that only signals the end of the track.
    function automatic evt_t end_event();
        evt_t e;
        e          = '0;
        e.kind     = KIND_NONE;
        e.valid    = 1'b1;
        e.finished = 1'b1;
        return e;
    endfunction

    // Program and channel pressure carry a single data byte.
    function automatic logic one_byte_msg(input logic [7:0] st);
        return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
    endfunction

    // Decode a complete channel message. A dropped message gives no result
    // unless it closes the track.
    function automatic evt_t decode_event(input logic [7:0] st, input logic [7:0] d1,
                                          input logic [7:0] d2, input logic fin);
        evt_t        e;
        kind_t       k;
        logic [15:0] raw;
        logic [15:0] bend_val;
        e        = '0;
        k        = KIND_NONE;
        raw      = {1'b0, d2, 7'b0} | {8'b0, d1};
        bend_val = '0;
        case (st[7:4])
            HI_NOTE_ON:  k = (d2[6:0] != 7'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
            HI_NOTE_OFF: k = KIND_NOTE_OFF;
            HI_PROGRAM:  k = KIND_PROGRAM;
            HI_CONTROL:
            begin
                if (d1[6:0] inside {7'd7, 7'd10, 7'd11, 7'd64, 7'd120, 7'd123})
                begin
                    k = KIND_CONTROL;
                end
            end
            HI_BEND:
            begin
                k        = KIND_BEND;
                bend_val = raw - BEND_CENTER;
            end
            default:     k = KIND_NONE;
        endcase
        if (k == KIND_NONE)
        begin
            e.kind     = KIND_NONE;
            e.valid    = fin;
            e.finished = fin;
        end
        else
        begin
            e.valid       = 1'b1;
            e.kind        = k;
            e.channel     = st[3:0];
            e.first_data  = d1[6:0];
            e.second_data = d2[6:0];
            e.bend        = signed'(bend_val);
            e.finished    = fin;
        end
        return e;
    endfunction

endpackage

// ===== sv/midi_track_event_parser.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: func, tdata: data_byte
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: kind, tlast: finished,
//                                                     tdata: event fields
//
// One track byte is accepted per cycle while the output is not stalled. A
// transfer lands in the input register, is parsed once the output register
// can take its result, and its result, if any, is then held in the output register.
// Reset (and a restart item) returns the parser to reading a delta time with
// the default tempo of 500000 us per quarter note.
// A stalled output holds the input register; the input stays ready as long as
// the input register is empty or moves on in the same cycle.
module midi_track_event_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [3:0] channel, [10:4] first_data,
                                        // [17:11] second_data, [33:18] bend,
                                        // [65:34] event_tick, [89:66] tempo,
                                        // [95:90] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // finished
);

    import mtep_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic [1:0] in_func_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    phase_t      phase_reg,          phase_next;
    logic [7:0]  running_status_reg, running_status_next;
    logic [31:0] vlq_accum_reg,      vlq_accum_next;
    logic [2:0]  vlq_bytes_reg,      vlq_bytes_next;
    logic [31:0] skip_remaining_reg, skip_remaining_next;
    logic [7:0]  meta_type_reg,      meta_type_next;
    logic [1:0]  meta_index_reg,     meta_index_next;
    logic [23:0] tempo_reg,          tempo_next;
    logic [15:0] tempo_partial_reg,  tempo_partial_next;
    logic [31:0] abs_tick_reg,       abs_tick_next;
    logic [7:0]  held_status_reg,    held_status_next;
    logic [7:0]  held_first_reg,     held_first_next;

    // Output register
    logic        out_valid_reg;
    evt_t        out_evt_reg;
    logic [31:0] out_tick_reg;
    logic [23:0] out_tempo_reg;

    logic        advance;
    evt_t        res;
    logic [31:0] vlq_shift;
    logic [2:0]  vlq_bytes_inc;
    logic        vlq_done;
    logic [23:0] tempo_word;

    // The parse step runs when the output register can take its result.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // One step of a variable-length quantity.
    assign vlq_shift     = {vlq_accum_reg[24:0], in_byte_reg[6:0]};
    assign vlq_bytes_inc = vlq_bytes_reg + 3'd1;
    assign vlq_done      = !in_byte_reg[7] || (vlq_bytes_inc >= 3'(VLQ_MAX_BYTES));
    assign tempo_word    = {tempo_partial_reg, in_byte_reg};

    // Input register takes a transfer whenever it is free or being emptied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_func_reg  <= FUNC_NOP;
            in_byte_reg  <= 8'd0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
                in_func_reg  <= s_axis_tuser;
                in_byte_reg  <= s_axis_tdata;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // Next parser state.
    always_comb
    begin
        phase_next          = phase_reg;
        running_status_next = running_status_reg;
        vlq_accum_next      = vlq_accum_reg;
        vlq_bytes_next      = vlq_bytes_reg;
        skip_remaining_next = skip_remaining_reg;
        meta_type_next      = meta_type_reg;
        meta_index_next     = meta_index_reg;
        tempo_next          = tempo_reg;
        tempo_partial_next  = tempo_partial_reg;
        abs_tick_next       = abs_tick_reg;
        held_status_next    = held_status_reg;
        held_first_next     = held_first_reg;

        if (advance)
        begin
            if (in_func_reg == FUNC_RESTART)
            begin
                phase_next          = PH_DELTA;
                running_status_next = 8'd0;
                vlq_accum_next      = 32'd0;
                vlq_bytes_next      = 3'd0;
                skip_remaining_next = 32'd0;
                meta_type_next      = 8'd0;
                meta_index_next     = 2'd0;
                tempo_next          = DEFAULT_TEMPO;
                tempo_partial_next  = 16'd0;
                abs_tick_next       = 32'd0;
                held_status_next    = 8'd0;
                held_first_next     = 8'd0;
            end
            else if (phase_reg != PH_DONE && in_func_reg == FUNC_END)
            begin
                // A partly read delta time still counts.
                if (phase_reg == PH_DELTA)
                begin
                    abs_tick_next = abs_tick_reg + vlq_accum_reg;
                end
                vlq_accum_next = 32'd0;
                vlq_bytes_next = 3'd0;
                phase_next     = PH_DONE;
            end
            else if (phase_reg != PH_DONE && in_func_reg == FUNC_BYTE)
            begin
                case (phase_reg)
                    PH_DELTA:
                    begin
                        vlq_accum_next = vlq_shift;
                        vlq_bytes_next = vlq_bytes_inc;
                        if (vlq_done)
                        begin
                            abs_tick_next  = abs_tick_reg + vlq_shift;
                            vlq_accum_next = 32'd0;
                            vlq_bytes_next = 3'd0;
                            phase_next     = PH_STATUS;
                        end
                    end
                    PH_STATUS:
                    begin
                        if (in_byte_reg[7])
                        begin
                            if (in_byte_reg < STATUS_SYSTEM)
                            begin
                                running_status_next = in_byte_reg;
                            end
                            if (in_byte_reg == STATUS_META)
                            begin
                                phase_next = PH_MTYPE;
                            end
                            else if (in_byte_reg == STATUS_SYSEX ||
                                     in_byte_reg == STATUS_ESCAPE)
                            begin
                                vlq_accum_next = 32'd0;
                                vlq_bytes_next = 3'd0;
                                phase_next     = PH_SXLEN;
                            end
                            else
                            begin
                                held_status_next = in_byte_reg;
                                phase_next       = PH_DATA1;
                            end
                        end
                        else if (running_status_reg == 8'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            held_status_next = running_status_reg;
                            held_first_next  = in_byte_reg;
                            phase_next       = one_byte_msg(running_status_reg) ?
                                               PH_DELTA : PH_DATA2;
                        end
                    end
                    PH_DATA1:
                    begin
                        held_first_next = in_byte_reg;
                        phase_next      = one_byte_msg(held_status_reg) ?
                                          PH_DELTA : PH_DATA2;
                    end
                    PH_DATA2:
                    begin
                        phase_next = PH_DELTA;
                    end
                    PH_MTYPE:
                    begin
                        meta_type_next = in_byte_reg;
                        vlq_accum_next = 32'd0;
                        vlq_bytes_next = 3'd0;
                        phase_next     = PH_MLEN;
                    end
                    PH_MLEN:
                    begin
                        vlq_accum_next = vlq_shift;
                        vlq_bytes_next = vlq_bytes_inc;
                        if (vlq_done)
                        begin
                            vlq_accum_next = 32'd0;
                            vlq_bytes_next = 3'd0;
                            if (meta_type_reg == META_END)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                // A tempo meta shorter than three bytes is ignored.
                                skip_remaining_next = vlq_shift;
                                tempo_partial_next  = 16'd0;
                                meta_index_next     = (meta_type_reg == META_TEMPO &&
                                                       vlq_shift < 32'd3) ?
                                                      TEMPO_BYTES : 2'd0;
                                phase_next          = (vlq_shift != 32'd0) ?
                                                      PH_SKIP : PH_DELTA;
                            end
                        end
                    end
                    PH_SXLEN:
                    begin
                        vlq_accum_next = vlq_shift;
                        vlq_bytes_next = vlq_bytes_inc;
                        if (vlq_done)
                        begin
                            vlq_accum_next      = 32'd0;
                            vlq_bytes_next      = 3'd0;
                            skip_remaining_next = vlq_shift;
                            tempo_partial_next  = 16'd0;
                            meta_index_next     = TEMPO_BYTES;
                            phase_next          = (vlq_shift != 32'd0) ?
                                                  PH_SKIP : PH_DELTA;
                        end
                    end
                    PH_SKIP:
                    begin
                        // The first three tempo body bytes build the new tempo.
                        if (meta_type_reg == META_TEMPO && meta_index_reg != TEMPO_BYTES)
                        begin
                            if (meta_index_reg == 2'd2)
                            begin
                                tempo_next = (tempo_word != 24'd0) ?
                                             tempo_word : DEFAULT_TEMPO;
                            end
                            else
                            begin
                                tempo_partial_next = {tempo_partial_reg[7:0], in_byte_reg};
                            end
                            meta_index_next = meta_index_reg + 2'd1;
                        end
                        skip_remaining_next = skip_remaining_reg - 32'd1;
                        if (skip_remaining_reg == 32'd1)
                        begin
                            phase_next = PH_DELTA;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Result of the current parse step.
    always_comb
    begin
        res = '0;
        if (advance && phase_reg != PH_DONE)
        begin
            if (in_func_reg == FUNC_END)
            begin
                case (phase_reg)
                    PH_DATA1: res = decode_event(held_status_reg, 8'd0, 8'd0, 1'b1);
                    PH_DATA2: res = decode_event(held_status_reg, held_first_reg,
                                                 8'd0, 1'b1);
                    default:  res = end_event();
                endcase
            end
            else if (in_func_reg == FUNC_BYTE)
            begin
                case (phase_reg)
                    PH_STATUS:
                    begin
                        if (!in_byte_reg[7])
                        begin
                            if (running_status_reg == 8'd0)
                            begin
                                res = end_event();
                            end
                            else if (one_byte_msg(running_status_reg))
                            begin
                                res = decode_event(running_status_reg, in_byte_reg,
                                                   8'd0, 1'b0);
                            end
                        end
                    end
                    PH_DATA1:
                    begin
                        if (one_byte_msg(held_status_reg))
                        begin
                            res = decode_event(held_status_reg, in_byte_reg, 8'd0, 1'b0);
                        end
                    end
                    PH_DATA2:
                    begin
                        res = decode_event(held_status_reg, held_first_reg,
                                           in_byte_reg, 1'b0);
                    end
                    PH_MLEN:
                    begin
                        if (vlq_done && meta_type_reg == META_END)
                        begin
                            res = end_event();
                        end
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_DELTA;
            running_status_reg <= 8'd0;
            vlq_accum_reg      <= 32'd0;
            vlq_bytes_reg      <= 3'd0;
            skip_remaining_reg <= 32'd0;
            meta_type_reg      <= 8'd0;
            meta_index_reg     <= 2'd0;
            tempo_reg          <= DEFAULT_TEMPO;
            tempo_partial_reg  <= 16'd0;
            abs_tick_reg       <= 32'd0;
            held_status_reg    <= 8'd0;
            held_first_reg     <= 8'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            running_status_reg <= running_status_next;
            vlq_accum_reg      <= vlq_accum_next;
            vlq_bytes_reg      <= vlq_bytes_next;
            skip_remaining_reg <= skip_remaining_next;
            meta_type_reg      <= meta_type_next;
            meta_index_reg     <= meta_index_next;
            tempo_reg          <= tempo_next;
            tempo_partial_reg  <= tempo_partial_next;
            abs_tick_reg       <= abs_tick_next;
            held_status_reg    <= held_status_next;
            held_first_reg     <= held_first_next;
        end
    end

    // Output register; the tick already includes a delta closed by an end item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_evt_reg   <= res;
            out_tick_reg  <= abs_tick_next;
            out_tempo_reg <= tempo_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_evt_reg.kind;
    assign m_axis_tlast  = out_evt_reg.finished;
    assign m_axis_tdata  = {6'd0, out_tempo_reg, out_tick_reg, out_evt_reg.bend,
                            out_evt_reg.second_data, out_evt_reg.first_data,
                            out_evt_reg.channel};

    // Once finished, only a restart leaves the done phase.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && !(advance && in_func_reg == FUNC_RESTART))
        |=> (phase_reg == PH_DONE))
        else $error("parser left the done phase without a restart");

    // A pending length or delta is only held while a quantity is being read.
    a_vlq_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DELTA && phase_reg != PH_MLEN && phase_reg != PH_SXLEN)
        |-> (vlq_bytes_reg == 3'd0 && vlq_accum_reg == 32'd0))
        else $error("variable-length count left over outside a length field");

    // Skipping never runs with nothing left to skip.
    a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_remaining_reg != 32'd0))
        else $error("skip phase with zero bytes remaining");

    // A result without an event kind is always the end of the track.
    a_none_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_evt_reg.kind == KIND_NONE)
        |-> (out_evt_reg.finished && out_evt_reg.channel == 4'd0 &&
             out_evt_reg.bend == 16'sd0))
        else $error("empty result without finished set");

endmodule

// ===== bench/midi_track_event_parser_tb.sv =====
`timescale 1ns / 1ps

module midi_track_event_parser_tb;

    import mtep_pkg::*;

    // Controller numbers that survive the filter.
    localparam logic [6:0] CC_VOLUME        = 7'd7;
    localparam logic [6:0] CC_PAN           = 7'd10;
    localparam logic [6:0] CC_EXPRESSION    = 7'd11;
    localparam logic [6:0] CC_SUSTAIN       = 7'd64;
    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

    localparam logic [7:0] NO_STATUS   = 8'h00;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         TRACK_BYTES = 860;

    typedef struct packed {
        logic [1:0] fn;
        logic [7:0] b;
        logic       drain;
    } track_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         channel;
        logic [6:0]         first_data;
        logic [6:0]         second_data;
        logic signed [15:0] bend;
        logic [31:0]        tick;
        logic [23:0]        tempo;
        logic               finished;
    } midi_event_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [1:0]  s_axis_tuser = FUNC_NOP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    track_item_t track_feed[$];
    midi_event_t expected_events[$];
    logic [7:0]  gen_running;
    int          n_sent = 0;
    int          n_accepted = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          error_count = 0;

    // Parser state as predicted from the accepted bytes.
    phase_t      pr_phase;
    logic [7:0]  pr_running;
    logic [31:0] pr_vlq;
    logic [2:0]  pr_vlq_count;
    logic [31:0] pr_skip;
    logic [7:0]  pr_meta;
    logic [1:0]  pr_tempo_idx;
    logic [23:0] pr_tempo;
    logic [15:0] pr_tempo_part;
    logic [31:0] pr_tick;
    logic [7:0]  pr_status;
    logic [7:0]  pr_first;

    midi_track_event_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void clear_parser();
        pr_phase      = PH_DELTA;
        pr_running    = NO_STATUS;
        pr_vlq        = '0;
        pr_vlq_count  = '0;
        pr_skip       = '0;
        pr_meta       = '0;
        pr_tempo_idx  = '0;
        pr_tempo      = DEFAULT_TEMPO;
        pr_tempo_part = '0;
        pr_tick       = '0;
        pr_status     = NO_STATUS;
        pr_first      = '0;
    endfunction

    // Shift one byte into the quantity; true when the quantity is complete.
    function automatic logic vlq_shift(input logic [7:0] b);
        pr_vlq       = {pr_vlq[24:0], b[6:0]};
        pr_vlq_count = pr_vlq_count + 3'd1;
        return !b[7] || (pr_vlq_count >= VLQ_MAX_BYTES);
    endfunction

    function automatic logic [31:0] vlq_take();
        logic [31:0] v;
        v            = pr_vlq;
        pr_vlq       = '0;
        pr_vlq_count = '0;
        return v;
    endfunction

    // Queue the result of a complete channel message. A dropped message gives
    // nothing unless it closes the track, and then only the end marker.
    function automatic void post_event(input logic [7:0] st, input logic [7:0] d1,
                                       input logic [7:0] d2, input logic fin);
        midi_event_t ev;
        logic [15:0] raw;
        ev          = '0;
        ev.kind     = KIND_NONE;
        ev.tick     = pr_tick;
        ev.tempo    = pr_tempo;
        ev.finished = fin;
        raw         = ({8'h00, d2} << 7) | {8'h00, d1};
        case (st[7:4])
            HI_NOTE_ON:  ev.kind = (d2[6:0] != 7'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
            HI_NOTE_OFF: ev.kind = KIND_NOTE_OFF;
            HI_PROGRAM:  ev.kind = KIND_PROGRAM;
            HI_CONTROL:
            begin
                if (d1[6:0] == CC_VOLUME || d1[6:0] == CC_PAN || d1[6:0] == CC_EXPRESSION ||
                    d1[6:0] == CC_SUSTAIN || d1[6:0] == CC_ALL_SOUND_OFF ||
                    d1[6:0] == CC_ALL_NOTES_OFF)
                begin
                    ev.kind = KIND_CONTROL;
                end
            end
            HI_BEND:
            begin
                ev.kind = KIND_BEND;
                ev.bend = raw - BEND_CENTER;
            end
            default:     ev.kind = KIND_NONE;
        endcase
        if (ev.kind != KIND_NONE)
        begin
            ev.channel     = st[3:0];
            ev.first_data  = d1[6:0];
            ev.second_data = d2[6:0];
        end
        if (ev.kind != KIND_NONE || fin)
        begin
            expected_events.push_back(ev);
        end
    endfunction

    function automatic void take_first(input logic [7:0] b);
        pr_first = b;
        if (pr_status[7:4] == HI_PROGRAM || pr_status[7:4] == HI_PRESSURE)
        begin
            pr_phase = PH_DELTA;
            post_event(pr_status, b, 8'h00, 1'b0);
        end
        else
        begin
            pr_phase = PH_DATA2;
        end
    endfunction

    function automatic void start_body_skip(input logic [31:0] len);
        pr_skip       = len;
        pr_tempo_idx  = '0;
        pr_tempo_part = '0;
        pr_phase      = (len != 0) ? PH_SKIP : PH_DELTA;
    endfunction

    // Advance the predicted parser by one accepted transfer.
    function automatic void track_step(input logic [1:0] fn, input logic [7:0] b);
        phase_t      was;
        logic [31:0] len;
        logic [23:0] t;
        if (fn == FUNC_RESTART)
        begin
            clear_parser();
        end
        else if (fn == FUNC_NOP || pr_phase == PH_DONE)
        begin
            // Nothing happens until a restart.
        end
        else if (fn == FUNC_END)
        begin
            was = pr_phase;
            if (was == PH_DELTA && pr_vlq_count != 0)
            begin
                pr_tick = pr_tick + pr_vlq;
            end
            void'(vlq_take());
            pr_phase = PH_DONE;
            if (was == PH_DATA1)
            begin
                post_event(pr_status, 8'h00, 8'h00, 1'b1);
            end
            else if (was == PH_DATA2)
            begin
                post_event(pr_status, pr_first, 8'h00, 1'b1);
            end
            else
            begin
                post_event(NO_STATUS, 8'h00, 8'h00, 1'b1);
            end
        end
        else
        begin
            case (pr_phase)
                PH_DELTA:
                begin
                    if (vlq_shift(b))
                    begin
                        pr_tick  = pr_tick + vlq_take();
                        pr_phase = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (b[7])
                    begin
                        if (b < STATUS_SYSTEM)
                        begin
                            pr_running = b;
                        end
                        if (b == STATUS_META)
                        begin
                            pr_phase = PH_MTYPE;
                        end
                        else if (b == STATUS_SYSEX || b == STATUS_ESCAPE)
                        begin
                            void'(vlq_take());
                            pr_phase = PH_SXLEN;
                        end
                        else
                        begin
                            pr_status = b;
                            pr_phase  = PH_DATA1;
                        end
                    end
                    else if (pr_running == NO_STATUS)
                    begin
                        pr_phase = PH_DONE;
                        post_event(NO_STATUS, 8'h00, 8'h00, 1'b1);
                    end
                    else
                    begin
                        pr_status = pr_running;
                        take_first(b);
                    end
                end
                PH_DATA1:
                begin
                    take_first(b);
                end
                PH_DATA2:
                begin
                    pr_phase = PH_DELTA;
                    post_event(pr_status, pr_first, b, 1'b0);
                end
                PH_MTYPE:
                begin
                    pr_meta = b;
                    void'(vlq_take());
                    pr_phase = PH_MLEN;
                end
                PH_MLEN:
                begin
                    if (vlq_shift(b))
                    begin
                        len = vlq_take();
                        if (pr_meta == META_END)
                        begin
                            pr_phase = PH_DONE;
                            post_event(NO_STATUS, 8'h00, 8'h00, 1'b1);
                        end
                        else
                        begin
                            start_body_skip(len);
                            // A tempo body too short to hold a value is only skipped.
                            if (pr_meta == META_TEMPO && len < TEMPO_BYTES)
                            begin
                                pr_tempo_idx = TEMPO_BYTES;
                            end
                        end
                    end
                end
                PH_SXLEN:
                begin
                    if (vlq_shift(b))
                    begin
                        start_body_skip(vlq_take());
                        pr_tempo_idx = TEMPO_BYTES;
                    end
                end
                PH_SKIP:
                begin
                    if (pr_meta == META_TEMPO && pr_tempo_idx < TEMPO_BYTES)
                    begin
                        if (pr_tempo_idx == TEMPO_BYTES - 2'd1)
                        begin
                            t        = {pr_tempo_part, b};
                            pr_tempo = (t != 0) ? t : DEFAULT_TEMPO;
                        end
                        else
                        begin
                            pr_tempo_part = {pr_tempo_part[7:0], b};
                        end
                        pr_tempo_idx = pr_tempo_idx + 2'd1;
                    end
                    pr_skip = pr_skip - 32'd1;
                    if (pr_skip == 0)
                    begin
                        pr_phase = PH_DELTA;
                    end
                end
                default: pr_phase = PH_DONE;
            endcase
        end
    endfunction

    function automatic void feed(input logic [1:0] fn, input logic [7:0] b);
        track_item_t it;
        it.fn    = fn;
        it.b     = b;
        it.drain = 1'b0;
        track_feed.push_back(it);
    endfunction

    // Encode a quantity, sometimes padded with extra leading bytes, up to five. In the five-byte
    // form the bits above 32 get junk, and the last byte may keep its top bit.
    function automatic void feed_vlq(input logic [31:0] v);
        int         n;
        logic [7:0] b;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
        begin
            n++;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(n, 5);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            b = 8'((v >> (7 * i)) & 32'h7f);
            if (i > 0)
            begin
                b[7] = 1'b1;
            end
            if (i == 4)
            begin
                b[6:4] = 3'($urandom);
            end
            if (i == 0 && n == 5 && $urandom_range(0, 1) == 1)
            begin
                b[7] = 1'b1;
            end
            feed(FUNC_BYTE, b);
        end
    endfunction

    function automatic void feed_delta();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            feed_vlq($urandom_range(0, 127));
        else if (pick < 17)
            feed_vlq($urandom_range(0, 16383));
        else if (pick < 19)
            feed_vlq($urandom_range(0, 2097151));
        else
            feed_vlq($urandom);
    endfunction

    // One channel message. Wild data bytes may have the top bit set, which
    // only an explicit status allows. At most max_data data bytes are sent.
    function automatic void feed_channel(input bit wild, input int max_data);
        logic [7:0] st;
        logic [7:0] d1;
        logic [7:0] d2;
        bit         reuse;
        reuse = gen_running != NO_STATUS && !wild && max_data == 2 &&
                $urandom_range(0, 2) == 0;
        st = reuse ? gen_running : {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        d1 = 8'($urandom_range(0, 127));
        d2 = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 127));
        if (st[7:4] == HI_CONTROL && $urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 5))
                0:       d1 = {1'b0, CC_VOLUME};
                1:       d1 = {1'b0, CC_PAN};
                2:       d1 = {1'b0, CC_EXPRESSION};
                3:       d1 = {1'b0, CC_SUSTAIN};
                4:       d1 = {1'b0, CC_ALL_SOUND_OFF};
                default: d1 = {1'b0, CC_ALL_NOTES_OFF};
            endcase
        end
        if (wild)
        begin
            d1 = 8'($urandom);
            d2 = 8'($urandom);
        end
        if (!reuse)
        begin
            feed(FUNC_BYTE, st);
            gen_running = st;
        end
        if (max_data > 0)
        begin
            feed(FUNC_BYTE, d1);
        end
        if (max_data > 1 && st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE)
        begin
            feed(FUNC_BYTE, d2);
        end
    endfunction

    // A well-formed track body with random events and a random way of ending.
    function automatic void feed_track(input bit drain);
        int         events;
        int         pick;
        int         n;
        bit         zero;
        logic [7:0] st;
        feed(FUNC_RESTART, 8'($urandom));
        if (drain)
        begin
            track_feed[track_feed.size() - 1].drain = 1'b1;
        end
        gen_running = NO_STATUS;
        events = $urandom_range(0, 12);
        for (int i = 0; i < events; i++)
        begin
            feed_delta();
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                feed_channel(1'b0, 2);
            end
            else if (pick < 58)
            begin
                feed_channel(1'b1, 2);
            end
            else if (pick < 68)
            begin
                // Tempo meta, mostly of the proper length.
                feed(FUNC_BYTE, STATUS_META);
                feed(FUNC_BYTE, META_TEMPO);
                n    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
                zero = $urandom_range(0, 4) == 0;
                feed_vlq(32'(n));
                for (int j = 0; j < n; j++)
                begin
                    feed(FUNC_BYTE, zero ? 8'h00 : 8'($urandom));
                end
            end
            else if (pick < 88)
            begin
                // Other meta events and sysex bodies are skipped.
                if (pick < 78)
                begin
                    feed(FUNC_BYTE, STATUS_META);
                    feed(FUNC_BYTE, 8'($urandom));
                end
                else
                begin
                    feed(FUNC_BYTE, ($urandom_range(0, 1) == 1) ? STATUS_SYSEX : STATUS_ESCAPE);
                end
                n = $urandom_range(0, 4);
                feed_vlq(32'(n));
                for (int j = 0; j < n; j++)
                begin
                    feed(FUNC_BYTE, 8'($urandom));
                end
            end
            else if (pick < 94)
            begin
                // System status with two data bytes, which is dropped.
                do
                begin
                    st = STATUS_SYSTEM | 8'($urandom_range(1, 14));
                end
                while (st == STATUS_ESCAPE);
                feed(FUNC_BYTE, st);
                feed(FUNC_BYTE, 8'($urandom));
                feed(FUNC_BYTE, 8'($urandom));
            end
            else
            begin
                feed(FUNC_NOP, 8'($urandom));
            end
        end

        pick = $urandom_range(0, 11);
        if (pick < 4)
        begin
            // End of body, sometimes inside a delta time.
            if ($urandom_range(0, 1) == 1)
            begin
                feed(FUNC_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
            end
            feed(FUNC_END, 8'($urandom));
        end
        else if (pick < 6)
        begin
            // End of body with a channel message that may still be waiting for data.
            feed_delta();
            feed_channel(1'b0, $urandom_range(0, 1));
            feed(FUNC_END, 8'($urandom));
        end
        else if (pick < 8)
        begin
            feed_delta();
            feed(FUNC_BYTE, STATUS_META);
            feed(FUNC_BYTE, META_END);
            feed_vlq($urandom_range(0, 3));
        end
        else if (pick < 9)
        begin
            feed_delta();
            feed(FUNC_BYTE, 8'($urandom_range(0, 127)));
            feed(FUNC_END, 8'($urandom));
        end
        else if (pick < 10)
        begin
            // Tempo body cut short by the end.
            feed_delta();
            feed(FUNC_BYTE, STATUS_META);
            feed(FUNC_BYTE, META_TEMPO);
            feed(FUNC_BYTE, 8'h03);
            feed(FUNC_BYTE, 8'($urandom));
            if ($urandom_range(0, 1) == 1)
            begin
                feed(FUNC_BYTE, 8'($urandom));
            end
            feed(FUNC_END, 8'($urandom));
        end
        // Otherwise the next restart cuts the track off.

        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 4);
            for (int j = 0; j < n; j++)
            begin
                pick = $urandom_range(0, 2);
                feed((pick == 0) ? FUNC_BYTE : (pick == 1) ? FUNC_END : FUNC_NOP,
                     8'($urandom));
            end
        end
    endfunction

    // Input side: predict each accepted transfer.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            track_step(s_axis_tuser, s_axis_tdata);
            n_accepted++;
        end
    end

    // Input side: present the next byte once the previous one is taken.
    always @(negedge clk)
    begin : drive_input
        track_item_t it;
        if (rst_n && n_sent == n_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (track_feed.size() > 0 &&
                     !(track_feed[0].drain && expected_events.size() > 0))
            begin
                it = track_feed.pop_front();
                s_axis_tuser  <= it.fn;
                s_axis_tdata  <= it.b;
                s_axis_tvalid <= 1'b1;
                n_sent++;
                if (track_feed.size() > 150 && (cycle_count % 1024) >= 256 &&
                    $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(1, 12);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure in bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (track_feed.size() > 150 && (cycle_count % 1024) >= 512 &&
                    $urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(1, 12);
                end
            end
        end
    end

    // Output side: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin : check_result
        midi_event_t want;
        midi_event_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind        = kind_t'(m_axis_tuser);
            got.channel     = m_axis_tdata[3:0];
            got.first_data  = m_axis_tdata[10:4];
            got.second_data = m_axis_tdata[17:11];
            got.bend        = $signed(m_axis_tdata[33:18]);
            got.tick        = m_axis_tdata[65:34];
            got.tempo       = m_axis_tdata[89:66];
            got.finished    = m_axis_tlast;
            if (expected_events.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result with nothing expected: kind %0d ch %0d tick %0d",
                             $time, got.kind, got.channel, got.tick);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got.kind !== want.kind || got.channel !== want.channel ||
                    got.first_data !== want.first_data ||
                    got.second_data !== want.second_data || got.bend !== want.bend ||
                    got.tick !== want.tick || got.tempo !== want.tempo ||
                    got.finished !== want.finished || m_axis_tdata[95:90] !== 6'd0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("%0t: expected kind %0d ch %0d d1 %0d d2 %0d bend %0d",
                                 $time, want.kind, want.channel, want.first_data,
                                 want.second_data, want.bend,
                                 " tick %0d tempo %0d fin %0d", want.tick, want.tempo,
                                 want.finished);
                        $display("%0t: actual   kind %0d ch %0d d1 %0d d2 %0d bend %0d",
                                 $time, got.kind, got.channel, got.first_data,
                                 got.second_data, got.bend,
                                 " tick %0d tempo %0d fin %0d pad %0h", got.tick, got.tempo,
                                 got.finished, m_axis_tdata[95:90]);
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("midi_track_event_parser_tb: errors");
        $finish;
    end

    initial
    begin : run_tracks
        int tracks;
        clear_parser();

        // A data byte before any status ends the track at once; what follows is
        // ignored, and so is the spare item code.
        feed(FUNC_BYTE, 8'h00);
        feed(FUNC_BYTE, 8'h40);
        feed(FUNC_BYTE, 8'h90);
        feed(FUNC_NOP, 8'hFF);
        feed(FUNC_RESTART, 8'h00);
        // Largest five-byte delta, then one more tick wraps the counter to zero.
        feed(FUNC_BYTE, 8'h8F);
        feed(FUNC_BYTE, 8'hFF);
        feed(FUNC_BYTE, 8'hFF);
        feed(FUNC_BYTE, 8'hFF);
        feed(FUNC_BYTE, 8'h7F);
        feed(FUNC_BYTE, 8'hC5);
        feed(FUNC_BYTE, 8'h7F);
        feed(FUNC_BYTE, 8'h01);
        // Pitch bend from raw bytes with the top bit set.
        feed(FUNC_BYTE, 8'hE0);
        feed(FUNC_BYTE, 8'hFF);
        feed(FUNC_BYTE, 8'hFF);
        // Largest tempo value.
        feed(FUNC_BYTE, 8'h00);
        feed(FUNC_BYTE, STATUS_META);
        feed(FUNC_BYTE, META_TEMPO);
        feed(FUNC_BYTE, 8'h03);
        feed(FUNC_BYTE, 8'hFF);
        feed(FUNC_BYTE, 8'hFF);
        feed(FUNC_BYTE, 8'hFF);
        // Note on with zero velocity turns into note off.
        feed(FUNC_BYTE, 8'h00);
        feed(FUNC_BYTE, 8'h93);
        feed(FUNC_BYTE, 8'h3C);
        feed(FUNC_BYTE, 8'h00);
        feed(FUNC_END, 8'h00);

        tracks = 0;
        while (track_feed.size() < TRACK_BYTES)
        begin
            feed_track(tracks % 8 == 0);
            tracks++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (track_feed.size() != 0 || n_sent != n_accepted || expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        if (expected_events.size() != 0)
        begin
            $display("%0d predicted results never arrived", expected_events.size());
        end
        if (error_count == 0 && expected_events.size() == 0)
        begin
            $display("midi_track_event_parser_tb: clean");
        end
        else
        begin
            $display("midi_track_event_parser_tb: errors");
        end
        $finish;
    end

endmodule
